// ===== hw/rtl/pcx_pkg.sv =====
// Shared types, constants and the byte-wide CRC update for the payload checksum block.
package pcx_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;
   localparam logic [7:0]  BYTE_TOP = 8'h80;

   // Number of bytes held in the delay line.
   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_ONE  = 2'd1,
      HELD_TWO  = 2'd2
   } held_count_type;

   // One finished checksum, passed from the tracker to the output buffer.
   typedef struct packed {
      logic        valid;
      logic [15:0] checksum;
   } result_type;

   // MSB-first CRC-16 update with one byte, eight bit steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic [7:0]  v;
      logic        fb;
      c = crc;
      v = data;
      for (int i = 0; i < 8; i++) begin
         fb = ((c & CRC_TOP) != 16'h0000) ^ ((v & BYTE_TOP) != 8'h00);
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         v = {v[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/pcx_track.sv =====
// Delay line, CRC accumulator and checksum formation for one packet at a time.
module pcx_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output pcx_pkg::result_type result
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] sum;

   always_comb begin
      crc_in   = crc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      case (count_ff)
         pcx_pkg::HELD_NONE: begin
            held0_in = data_byte;
            count_in = pcx_pkg::HELD_ONE;
         end
         pcx_pkg::HELD_ONE: begin
            held1_in = data_byte;
            count_in = pcx_pkg::HELD_TWO;
         end
         default: begin
            // A full line: the oldest byte moves into the CRC.
            crc_in   = pcx_pkg::crc_feed(crc_ff, held0_ff);
            held0_in = held1_ff;
            held1_in = data_byte;
            count_in = pcx_pkg::HELD_TWO;
         end
      endcase

      if (count_in == pcx_pkg::HELD_ONE) begin
         sum = crc_in ^ {8'h00, held0_in};
      end else begin
         sum = crc_in ^ {held0_in, held1_in};
      end

      result.valid    = take && last_byte;
      result.checksum = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= 16'h0000;
         held0_ff <= 8'h00;
         held1_ff <= 8'h00;
         count_ff <= pcx_pkg::HELD_NONE;
      end else if (take) begin
         if (last_byte) begin
            crc_ff   <= 16'h0000;
            held0_ff <= 8'h00;
            held1_ff <= 8'h00;
            count_ff <= pcx_pkg::HELD_NONE;
         end else begin
            crc_ff   <= crc_in;
            held0_ff <= held0_in;
            held1_ff <= held1_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// ===== hw/rtl/pcx_skid.sv =====
// Two-entry output register with skid stage for the checksum channel.
module pcx_skid (
   input  logic                clock,
   input  logic                reset,
   input  pcx_pkg::result_type result,
   output logic                full,
   output logic                out_valid,
   output logic [15:0]         out_checksum,
   input  logic                out_stall
);

   logic        main_valid_ff;
   logic [15:0] main_data_ff;
   logic        skid_valid_ff;
   logic [15:0] skid_data_ff;
   logic        pop;

   assign pop          = main_valid_ff && !out_stall;
   assign full         = skid_valid_ff;
   assign out_valid    = main_valid_ff;
   assign out_checksum = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_data_ff  <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (result.valid) begin
         if (main_valid_ff && !pop) begin
            skid_data_ff  <= result.checksum;
            skid_valid_ff <= 1'b1;
         end else begin
            main_data_ff  <= result.checksum;
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

// ===== hw/rtl/payload_crc16_tail_xor.sv =====
// Top level of the packet checksum block: CRC-16 over all but the last two bytes, tail XORed in.
//
// Usage: a packet enters on the req_ channel one byte per transfer, with
// req_last_byte high on its final byte. Each packet yields exactly one
// transfer on the rsp_ channel, carrying rsp_checksum: the MSB-first CRC-16
// (polynomial 0x1021, initial value zero) of every byte but the final two,
// XORed with the second-to-last byte in the upper half and the last byte in
// the lower half. A one-byte packet returns that byte zero-extended.
// Output: the checksum is registered, in the skid entry while the output is held.
// Throughput: one byte per cycle while req_stall is low; the byte-wide CRC
// update fits between the state registers, so bytes can follow in every cycle.
// Stalls: results sit in an output register backed by one skid entry, so
// input keeps flowing while a result waits. req_stall rises only once both
// entries hold results, and falls the cycle after the receiver takes one.
// Reset: synchronous and active high; it clears the CRC, the delay line and
// both output entries, so the first byte afterwards starts a new packet.
module payload_crc16_tail_xor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum
);

   pcx_pkg::result_type result;
   logic                buffer_full;
   logic                take;

   // A byte transfer happens whenever a byte is offered and the skid entry is free.
   assign take      = req_valid && !buffer_full;
   assign req_stall = buffer_full;

   // Packet state and checksum formation.
   pcx_track u_track (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .result    (result)
   );

   // Result register plus skid entry towards the receiver.
   pcx_skid u_skid (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .full         (buffer_full),
      .out_valid    (rsp_valid),
      .out_checksum (rsp_checksum),
      .out_stall    (rsp_stall)
   );

endmodule

// ===== bench/payload_crc16_tail_xor_test.sv =====
// Self-checking testbench for the packet checksum block: directed and random packets.
`timescale 1ns / 1ps

module payload_crc16_tail_xor_test;

   // Tracks the packet in flight on the byte channel and keeps the checksums
   // still owed by the block, oldest first.
   class checksum_board;
      logic [15:0]             running_crc;
      logic [7:0]              older_byte;
      logic [7:0]              newer_byte;
      pcx_pkg::held_count_type fill;
      logic [15:0]             owed_sums[$];
      int                      faults;
      int                      sums_matched;
      int                      packets_seen;

      function new();
         faults       = 0;
         sums_matched = 0;
         packets_seen = 0;
         start_packet();
      endfunction

      function void start_packet();
         running_crc = 16'h0000;
         older_byte  = 8'h00;
         newer_byte  = 8'h00;
         fill        = pcx_pkg::HELD_NONE;
      endfunction

      // Byte-at-a-time form: fold the byte into the top half, then shift eight times.
      function logic [15:0] crc_with_byte(input logic [15:0] crc, input logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
               c = {c[14:0], 1'b0} ^ pcx_pkg::CRC_POLY;
            end else begin
               c = {c[14:0], 1'b0};
            end
         end
         return c;
      endfunction

      function void note_byte(input logic [7:0] b, input logic fin);
         case (fill)
            pcx_pkg::HELD_NONE: begin
               older_byte = b;
               fill       = pcx_pkg::HELD_ONE;
            end
            pcx_pkg::HELD_ONE: begin
               newer_byte = b;
               fill       = pcx_pkg::HELD_TWO;
            end
            default: begin
               running_crc = crc_with_byte(running_crc, older_byte);
               older_byte  = newer_byte;
               newer_byte  = b;
               fill        = pcx_pkg::HELD_TWO;
            end
         endcase
         if (fin) begin
            if (fill == pcx_pkg::HELD_ONE) begin
               owed_sums.push_back({8'h00, older_byte});
            end else begin
               owed_sums.push_back(running_crc ^ {older_byte, newer_byte});
            end
            packets_seen++;
            start_packet();
         end
      endfunction

      function void check_checksum(input logic [15:0] got);
         logic [15:0] want;
         if (owed_sums.size() == 0) begin
            $error("rsp_checksum: no checksum expected, got %h", got);
            faults++;
         end else begin
            want = owed_sums.pop_front();
            if (got !== want) begin
               $error("rsp_checksum: expected %h, actual %h", want, got);
               faults++;
            end else begin
               sums_matched++;
            end
         end
      endfunction

      function int owed();
         return owed_sums.size();
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [15:0] rsp_checksum;

   // Both sides may idle while this is set; it is cleared for quiet stretches
   // and for the whole of the closing part of the run.
   bit            idle_on    = 1'b1;
   int            bytes_sent = 0;
   checksum_board board      = new();

   payload_crc16_tail_xor dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_checksum  (rsp_checksum)
   );

   always #5 clock = ~clock;

   // Watch both channels. Everything reads the values from just before the
   // edge, because the block and the drivers here only change on the edge
   // through nonblocking assignments. A result is checked before the byte of
   // the same edge is noted; the result always belongs to an earlier packet.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_checksum(rsp_checksum);
         end
         if (req_valid && !req_stall) begin
            board.note_byte(req_data_byte, req_last_byte);
         end
      end
   end

   // Receiver back-pressure: random stall bursts, started only while idling is on.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0) begin
            rsp_stall <= 1'b0;
         end
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(1, 12);
      end
   end

   // Offer one byte and hold it until the block takes it. Called straight
   // after a rising edge, so the payload changes only once per transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Occasionally drop valid for a random gap between bytes, while idling is on.
   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop sending until every owed checksum has been delivered, or a cycle
   // limit runs out. The loop waits on the clock before it checks, so valid is never lowered and
   // raised again within one time step.
   task automatic hold_until_drained(input int limit);
      int waited;
      waited    = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (board.owed() != 0 && waited < limit);
   endtask

   // Packet boundaries are marked by bit 8. The opening set covers one-byte
   // packets at both extremes, two-byte packets where the CRC stays zero, a
   // three-byte packet, a longer packet that drives the CRC through its top
   // bits, and single-byte packets back to back right after a long one.
   logic [8:0] opening_bytes [20] = '{
      {1'b1, 8'h00},
      {1'b1, 8'hFF},
      {1'b0, 8'hFF}, {1'b1, 8'h00},
      {1'b0, 8'h00}, {1'b1, 8'hFF},
      {1'b0, 8'h80}, {1'b0, 8'h01}, {1'b1, 8'h7F},
      {1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'hFF}, {1'b0, 8'h00},
      {1'b0, 8'h01}, {1'b0, 8'h80}, {1'b0, 8'hFE}, {1'b1, 8'h7F},
      {1'b1, 8'hA5},
      {1'b1, 8'h01},
      {1'b1, 8'h02}
   };

   initial begin
      int pkt_len;
      int pick;
      logic [7:0] b;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) begin
         send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
         sender_gap();
      end

      // Let the pipeline empty completely once before the random traffic.
      hold_until_drained(2000);

      // Random packets. Most are short, some medium and a few long. Every
      // fourth stretch of about 150 bytes runs without idling, and the last
      // three hundred bytes or so run flat out on both sides.
      while (bytes_sent < 1900) begin
         idle_on = (bytes_sent < 1600) && ((bytes_sent / 150) % 4 != 3);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            pkt_len = $urandom_range(1, 6);
         end else if (pick < 95) begin
            pkt_len = $urandom_range(7, 24);
         end else begin
            pkt_len = $urandom_range(25, 64);
         end
         for (int k = 0; k < pkt_len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               b = 8'h00;
            end else if (pick == 1) begin
               b = 8'hFF;
            end else begin
               b = 8'($urandom_range(0, 255));
            end
            send_byte(b, k == pkt_len - 1);
            sender_gap();
         end
      end

      // Closing: wait for the last checksums, then a few more cycles so that
      // any stray extra result would still be caught.
      hold_until_drained(5000);
      repeat (8) @(posedge clock);
      if (board.owed() != 0) begin
         $error("rsp_checksum: %0d expected checksums never arrived", board.owed());
         board.faults++;
      end

      $display("Sent %0d bytes in %0d packets, including one-byte and two-byte packets.",
               bytes_sent, board.packets_seen);
      $display("Checked %0d checksums under random idling on both channels.",
               board.sums_matched);
      if (board.faults == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run could take.
   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
